>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define PMA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pma checker: property failed");

// same-cycle implication
`define PMA_ASSERT_IMPL(label, ante, cons) \
    `PMA_ASSERT(label, (ante) |-> (cons))

// next-cycle implication
`define PMA_ASSERT_NEXT(label, ante, cons) \
    `PMA_ASSERT(label, (ante) |=> (cons))

`endif

>>> src/pma_pkg.sv
// shared constants and types of the polynomial multiply-add block
package pma_pkg;

    localparam int MAX_DEGREE = 31;
    localparam int CAPACITY   = MAX_DEGREE + 1;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int COEFF_W    = 32;
    localparam int POWER_W    = 6;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_FIRST,
        CMD_SECOND,
        CMD_RUN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic [COEFF_W-1:0]   value;
        logic                 mul;
    } cmd_t;

    typedef struct packed {
        logic [COEFF_W-1:0]   coeff;
        logic [POWER_W-1:0]   power;
        logic                 last;
        logic                 too_long;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_START,
        BK_RUN
    } back_state_t;

endpackage

>>> src/polynomial_multiply_add.sv
// top level of the polynomial adder / schoolbook multiplier
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------
//  input    | push / full      | operand, coeff_in, last_coeff, mode
//  result   | empty / pop      | coeff_out, power, last_out, too_long
//
// the back end stores coefficient loads while idle; a four-entry command queue
// sits in front. an operation with result length T runs a setup state, then
// issues T terms (add) or T*(T+1)/2 terms (multiply), one term per cycle while
// the result queue has room, through the single 32x32 multiplier.
// the four-entry result queue throttles term issue when pop is held low.
// reset clears all counts and queues; store contents are undefined until written.
module polynomial_multiply_add (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               operand,
    input  logic signed [pma_pkg::COEFF_W-1:0] coeff_in,
    input  logic                               last_coeff,
    input  logic                               mode,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [pma_pkg::COEFF_W-1:0] coeff_out,
    output logic [pma_pkg::POWER_W-1:0]        power,
    output logic                               last_out,
    output logic                               too_long
);

    import pma_pkg::*;

    logic                  cmd_valid;
    cmd_t                  cmd;
    logic                  cmd_pop;
    logic [OUTQ_CNT_W-1:0] res_count;
    logic                  res_push;
    result_t               res_in;
    result_t               res_out;

    pma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operand    (operand),
        .coeff_in   (coeff_in),
        .last_coeff (last_coeff),
        .mode       (mode),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    pma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res_in    (res_in)
    );

    pma_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res_in    (res_in),
        .res_count (res_count),
        .empty     (empty),
        .pop       (pop),
        .res_out   (res_out)
    );

    assign coeff_out = res_out.coeff;
    assign power     = res_out.power;
    assign last_out  = res_out.last;
    assign too_long  = res_out.too_long;

endmodule

>>> src/pma_ram.sv
// generic single-write, single-read ram with registered read data
module pma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/pma_front.sv
// front end: accepts input transactions, classifies them and queues commands
module pma_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      operand,
    input  logic [pma_pkg::COEFF_W-1:0] coeff_in,
    input  logic                      last_coeff,
    input  logic                      mode,
    output logic                      cmd_valid,
    output pma_pkg::cmd_t             cmd,
    input  logic                      cmd_pop
);

    import pma_pkg::*;

    cmd_t                  queue_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wptr_reg;
    logic [CMDQ_PTR_W-1:0] rptr_reg;
    logic [CMDQ_PTR_W:0]   count_reg;
    cmd_t                  cmd_in;
    logic                  do_push;
    logic                  do_pop;

    always_comb
    begin
        cmd_in.value = coeff_in;
        cmd_in.mul   = mode;
        priority if (!operand)
        begin
            cmd_in.kind = CMD_FIRST;
        end
        else if (last_coeff)
        begin
            cmd_in.kind = CMD_RUN;
        end
        else
        begin
            cmd_in.kind = CMD_SECOND;
        end
    end

    assign full      = (count_reg == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

>>> src/pma_outq.sv
// result queue in front of the output ports
module pma_outq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          res_push,
    input  pma_pkg::result_t              res_in,
    output logic [pma_pkg::OUTQ_CNT_W-1:0] res_count,
    output logic                          empty,
    input  logic                          pop,
    output pma_pkg::result_t              res_out
);

    import pma_pkg::*;

    result_t               queue_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wptr_reg;
    logic [OUTQ_PTR_W-1:0] rptr_reg;
    logic [OUTQ_CNT_W-1:0] count_reg;
    logic                  do_pop;

    assign empty     = (count_reg == '0);
    assign res_count = count_reg;
    assign res_out   = queue_reg[rptr_reg];
    assign do_pop    = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (res_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (res_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!res_push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            queue_reg[wptr_reg] <= res_in;
        end
    end

endmodule

>>> src/pma_back.sv
// back end: coefficient stores, term sequencer and multiply-accumulate pipeline
module pma_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  pma_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    input  logic [pma_pkg::OUTQ_CNT_W-1:0] res_count,
    output logic                           res_push,
    output pma_pkg::result_t               res_in
);

    import pma_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;

    logic [COUNT_W-1:0]   first_count_reg;
    logic [COUNT_W-1:0]   second_count_reg;
    logic                 ovf_reg;
    logic                 mul_reg;
    logic                 run_ovf_reg;
    logic [POWER_W-1:0]   k_reg;
    logic [POWER_W-1:0]   i_reg;
    logic [POWER_W-1:0]   last_k_reg;

    logic                 s1_valid_reg;
    logic                 s1_fv_reg;
    logic                 s1_gv_reg;
    logic                 s1_last_term_reg;
    logic [POWER_W-1:0]   s1_k_reg;
    logic [POWER_W-1:0]   s1_last_k_reg;
    logic                 s1_mul_reg;
    logic                 s1_ovf_reg;

    logic                 s2_valid_reg;
    logic [COEFF_W-1:0]   s2_term_reg;
    logic                 s2_last_term_reg;
    logic [POWER_W-1:0]   s2_k_reg;
    logic [POWER_W-1:0]   s2_last_k_reg;
    logic                 s2_ovf_reg;

    logic [COEFF_W-1:0]   acc_reg;

    logic                 first_we;
    logic                 second_we;
    logic                 issue;
    logic                 term_done;
    logic                 k_done;
    logic                 first_full;
    logic                 second_full;
    logic [POWER_W-1:0]   gidx;
    logic [COEFF_W-1:0]   first_rdata;
    logic [COEFF_W-1:0]   second_rdata;
    logic [COEFF_W-1:0]   f_val;
    logic [COEFF_W-1:0]   g_val;
    logic [COEFF_W-1:0]   prod;
    logic [COEFF_W-1:0]   term;
    logic [COEFF_W-1:0]   sum;
    logic [COUNT_W-1:0]   n1_eff;
    logic [COUNT_W:0]     span;
    logic [POWER_W-1:0]   last_k_next;
    logic [OUTQ_CNT_W:0]  inflight;
    logic                 credit_ok;

    pma_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (CAPACITY)
    ) u_first_ram (
        .clk   (clk),
        .we    (first_we),
        .waddr (first_count_reg[ADDR_W-1:0]),
        .wdata (cmd.value),
        .raddr (i_reg[ADDR_W-1:0]),
        .rdata (first_rdata)
    );

    pma_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (CAPACITY)
    ) u_second_ram (
        .clk   (clk),
        .we    (second_we),
        .waddr (second_count_reg[ADDR_W-1:0]),
        .wdata (cmd.value),
        .raddr (gidx[ADDR_W-1:0]),
        .rdata (second_rdata)
    );

    assign first_full  = (first_count_reg == COUNT_W'(CAPACITY));
    assign second_full = (second_count_reg == COUNT_W'(CAPACITY));
    assign gidx        = mul_reg ? (k_reg - i_reg) : k_reg;
    assign term_done   = (i_reg == k_reg);
    assign k_done      = (k_reg == last_k_reg);

    // results in the output queue or already on their way to it
    assign inflight  = (OUTQ_CNT_W + 1)'(res_count)
                     + (OUTQ_CNT_W + 1)'(s1_valid_reg && s1_last_term_reg)
                     + (OUTQ_CNT_W + 1)'(s2_valid_reg && s2_last_term_reg);
    assign credit_ok = (inflight < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));

    // result length, less one
    always_comb
    begin
        n1_eff = (first_count_reg == '0) ? COUNT_W'(1) : first_count_reg;
        if (mul_reg)
        begin
            span = {1'b0, n1_eff} + {1'b0, second_count_reg} - (COUNT_W + 1)'(2);
        end
        else if (n1_eff > second_count_reg)
        begin
            span = {1'b0, n1_eff} - (COUNT_W + 1)'(1);
        end
        else
        begin
            span = {1'b0, second_count_reg} - (COUNT_W + 1)'(1);
        end
        last_k_next = span[POWER_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_RUN))
                begin
                    state_next = BK_START;
                end
            end
            BK_START:
            begin
                state_next = BK_RUN;
            end
            BK_RUN:
            begin
                if (issue && term_done && k_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop   = (state_reg == BK_IDLE) && cmd_valid;
        first_we  = cmd_pop && (cmd.kind == CMD_FIRST) && !first_full;
        second_we = cmd_pop && ((cmd.kind == CMD_SECOND) || (cmd.kind == CMD_RUN))
                    && !second_full;
        issue     = (state_reg == BK_RUN) && credit_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            ovf_reg          <= 1'b0;
            mul_reg          <= 1'b0;
            run_ovf_reg      <= 1'b0;
            k_reg            <= '0;
            i_reg            <= '0;
            last_k_reg       <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            acc_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cmd_pop)
            begin
                unique case (cmd.kind)
                    CMD_FIRST:
                    begin
                        if (first_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            first_count_reg <= first_count_reg + 1'b1;
                        end
                    end
                    CMD_SECOND, CMD_RUN:
                    begin
                        if (second_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            second_count_reg <= second_count_reg + 1'b1;
                        end
                        if (cmd.kind == CMD_RUN)
                        begin
                            mul_reg <= cmd.mul;
                        end
                    end
                    default:
                    begin
                        ovf_reg <= ovf_reg;
                    end
                endcase
            end

            if (state_reg == BK_START)
            begin
                last_k_reg  <= last_k_next;
                k_reg       <= '0;
                i_reg       <= '0;
                run_ovf_reg <= ovf_reg;
            end

            if (issue)
            begin
                if (term_done)
                begin
                    if (k_done)
                    begin
                        first_count_reg  <= '0;
                        second_count_reg <= '0;
                        ovf_reg          <= 1'b0;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        i_reg <= mul_reg ? '0 : (k_reg + 1'b1);
                    end
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end

            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;

            if (s2_valid_reg)
            begin
                acc_reg <= s2_last_term_reg ? '0 : sum;
            end
        end
    end

    // operand fetch and term forming
    assign f_val = s1_fv_reg ? first_rdata : '0;
    assign g_val = s1_gv_reg ? second_rdata : '0;
    assign prod  = f_val * g_val;
    assign term  = s1_mul_reg ? prod : (f_val + g_val);
    assign sum   = acc_reg + s2_term_reg;

    always_ff @(posedge clk)
    begin
        s1_fv_reg        <= ({1'b0, i_reg} < {1'b0, first_count_reg});
        s1_gv_reg        <= ({1'b0, gidx} < {1'b0, second_count_reg});
        s1_last_term_reg <= term_done;
        s1_k_reg         <= k_reg;
        s1_last_k_reg    <= last_k_reg;
        s1_mul_reg       <= mul_reg;
        s1_ovf_reg       <= run_ovf_reg;

        s2_term_reg      <= term;
        s2_last_term_reg <= s1_last_term_reg;
        s2_k_reg         <= s1_k_reg;
        s2_last_k_reg    <= s1_last_k_reg;
        s2_ovf_reg       <= s1_ovf_reg;
    end

    always_comb
    begin
        res_push        = s2_valid_reg && s2_last_term_reg;
        res_in.coeff    = sum;
        res_in.power    = s2_k_reg;
        res_in.last     = (s2_k_reg == s2_last_k_reg);
        res_in.too_long = s2_ovf_reg;
    end

endmodule

>>> src/pma_checker.sv
// port-level checker for the polynomial multiply-add block, with its bind
`include "assert_macros.svh"

module pma_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic                               full,
    input  logic                               operand,
    input  logic                               last_coeff,
    input  logic                               mode,
    input  logic                               empty,
    input  logic                               pop,
    input  logic signed [pma_pkg::COEFF_W-1:0] coeff_out,
    input  logic [pma_pkg::POWER_W-1:0]        power,
    input  logic                               last_out,
    input  logic                               too_long
);

    import pma_pkg::*;

    logic [POWER_W-1:0] exp_power_reg;
    logic               prev_too_long_reg;
    logic               res_taken;
    logic               in_taken;

    assign res_taken = pop && !empty;
    assign in_taken  = push && !full && operand && last_coeff && mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_power_reg     <= '0;
            prev_too_long_reg <= 1'b0;
        end
        else if (res_taken)
        begin
            exp_power_reg     <= last_out ? '0 : (power + 1'b1);
            prev_too_long_reg <= too_long;
        end
    end

    // result coefficients of one operation come out in ascending powers from zero
    `PMA_ASSERT_IMPL(a_power_sequence, !empty, power == exp_power_reg)

    // the truncation flag is the same on every result of one operation
    `PMA_ASSERT_IMPL(a_flag_constant, !empty && (exp_power_reg != '0),
                     too_long == prev_too_long_reg)

    // a waiting result transaction holds until it is taken
    `PMA_ASSERT_NEXT(a_result_hold, !empty && !pop,
                     !empty && $stable(coeff_out) && $stable(power) && $stable(last_out))

    // no result transaction can be ready in the cycle right after reset release
    `PMA_ASSERT_IMPL(a_no_early_result, $rose(rst_n) && !in_taken, empty)

endmodule

bind polynomial_multiply_add pma_checker u_pma_checker (.*);

>>> sim/polynomial_multiply_add_tb.sv
// self-checking testbench for the polynomial adder / schoolbook multiplier
module polynomial_multiply_add_tb;

    import pma_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 30;

    typedef struct packed {
        logic               op;
        logic [COEFF_W-1:0] value;
        logic               is_last;
        logic               mul;
        logic [7:0]         reps;
        logic               typed;
        result_t            want;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic                      operand;
    logic signed [COEFF_W-1:0] coeff_in;
    logic                      last_coeff;
    logic                      mode;
    logic                      empty;
    logic                      pop;
    logic signed [COEFF_W-1:0] coeff_out;
    logic [POWER_W-1:0]        power;
    logic                      last_out;
    logic                      too_long;

    logic [COEFF_W-1:0] poly_coeffs [2][CAPACITY];
    int                 poly_len [2];
    logic               truncated;
    result_t            expected_terms [$];
    row_t               script [$];

    int  failures = 0;
    int  coeffs_sent = 0;
    int  ops_done = 0;
    int  terms_checked = 0;
    int  backpressure_cycles = 0;
    bit  sender_calm = 1'b0;
    bit  recv_calm = 1'b0;
    bit  stall_request = 1'b0;

    polynomial_multiply_add uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operand    (operand),
        .coeff_in   (coeff_in),
        .last_coeff (last_coeff),
        .mode       (mode),
        .empty      (empty),
        .pop        (pop),
        .coeff_out  (coeff_out),
        .power      (power),
        .last_out   (last_out),
        .too_long   (too_long)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t term(input logic [COEFF_W-1:0] c, input logic [POWER_W-1:0] p,
                                     input logic l, input logic t);
        result_t r;
        r.coeff    = c;
        r.power    = p;
        r.last     = l;
        r.too_long = t;
        return r;
    endfunction

    function automatic logic [COEFF_W-1:0] stored(input int which, input int idx);
        if (idx < poly_len[which])
            return poly_coeffs[which][idx];
        return '0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_len(input bit second);
        if ($urandom_range(0, 99) < 6)
            return $urandom_range(30, 34);
        return second ? $urandom_range(1, 6) : $urandom_range(0, 5);
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic predict_coefficients(input logic op, input logic [COEFF_W-1:0] value,
                                        input logic is_last, input logic mul);
        int                 which;
        int                 n1;
        int                 n2;
        int                 total;
        logic [COEFF_W-1:0] acc;
        logic [COEFF_W-1:0] prod;
        which = op ? 1 : 0;
        if (poly_len[which] < CAPACITY)
        begin
            poly_coeffs[which][poly_len[which]] = value;
            poly_len[which]++;
        end
        else
            truncated = 1'b1;
        if (op && is_last)
        begin
            n1 = (poly_len[0] == 0) ? 1 : poly_len[0];
            n2 = poly_len[1];
            total = mul ? n1 + n2 - 1 : ((n1 > n2) ? n1 : n2);
            for (int k = 0; k < total; k++)
            begin
                acc = '0;
                if (mul)
                begin
                    for (int i = 0; i <= k; i++)
                    begin
                        prod = stored(0, i) * stored(1, k - i);
                        acc = acc + prod;
                    end
                end
                else
                    acc = stored(0, k) + stored(1, k);
                expected_terms.push_back(term(acc, k[POWER_W-1:0], k == total - 1, truncated));
            end
            poly_len[0] = 0;
            poly_len[1] = 0;
            truncated = 1'b0;
            ops_done++;
        end
    endtask

    task automatic send_coefficient(input logic op, input logic [COEFF_W-1:0] value,
                                    input logic is_last, input logic mul,
                                    input logic typed, input result_t want);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        operand    <= op;
        coeff_in   <= value;
        last_coeff <= is_last;
        mode       <= mul;
        @(posedge clk);
        while (full)
        begin
            backpressure_cycles++;
            @(posedge clk);
        end
        coeffs_sent++;
        predict_coefficients(op, value, is_last, mul);
        if (typed)
            expected_terms[expected_terms.size() - 1] = want;
    endtask

    task automatic add_row(input logic op, input logic [COEFF_W-1:0] value, input logic is_last,
                           input logic mul, input int reps, input logic typed,
                           input result_t want);
        row_t r;
        r.op      = op;
        r.value   = value;
        r.is_last = is_last;
        r.mul     = mul;
        r.reps    = reps[7:0];
        r.typed   = typed;
        r.want    = want;
        script.push_back(r);
    endtask

    // result side: random pop gaps, one long hold-off on request
    initial
    begin
        int hold;
        hold = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 149) == 0)
                recv_calm = !recv_calm;
            if (stall_request)
            begin
                stall_request = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
                hold = (recv_calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_terms.size() == 0)
            begin
                $error("result transaction with no expected term: coeff %h power %0d",
                       coeff_out, power);
                failures++;
            end
            else
            begin
                want = expected_terms.pop_front();
                terms_checked++;
                if (coeff_out !== want.coeff)
                begin
                    $error("coeff_out: expected %h, actual %h", want.coeff, coeff_out);
                    failures++;
                end
                if (power !== want.power)
                begin
                    $error("power: expected %0d, actual %0d", want.power, power);
                    failures++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out: expected %0b, actual %0b", want.last, last_out);
                    failures++;
                end
                if (too_long !== want.too_long)
                begin
                    $error("too_long: expected %0b, actual %0b", want.too_long, too_long);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("polynomial_multiply_add_tb: FAIL");
        $finish;
    end

    initial
    begin
        row_t    r;
        result_t none;
        int      n1;
        int      n2;
        int      first_left;
        int      second_left;
        int      op_idx;
        int      random_start;
        bit      mul;
        bit      broken;

        none       = term(0, 0, 0, 0);
        rst_n      = 1'b0;
        push       = 1'b0;
        operand    = 1'b0;
        coeff_in   = '0;
        last_coeff = 1'b0;
        mode       = 1'b0;
        poly_len[0] = 0;
        poly_len[1] = 0;
        truncated  = 1'b0;

        // single-term sums and products with values read off directly
        add_row(0, 7, 1, 0, 1, 0, none);
        add_row(1, 5, 1, 0, 1, 1, term(12, 0, 1, 0));
        add_row(0, 32'h7fff_ffff, 1, 0, 1, 0, none);
        add_row(1, 1, 1, 0, 1, 1, term(32'h8000_0000, 0, 1, 0));
        add_row(0, 32'h8000_0000, 1, 0, 1, 0, none);
        add_row(1, 32'h8000_0000, 1, 1, 1, 1, term(0, 0, 1, 0));
        add_row(0, 32'h7fff_ffff, 1, 0, 1, 0, none);
        add_row(1, 32'h7fff_ffff, 1, 1, 1, 1, term(1, 0, 1, 0));
        add_row(0, 32'hffff_ffff, 1, 1, 1, 0, none);
        add_row(1, 32'hffff_ffff, 1, 1, 1, 1, term(1, 0, 1, 0));
        // empty first operand
        add_row(1, 32'hdead_beef, 1, 0, 1, 1, term(32'hdead_beef, 0, 1, 0));
        add_row(1, 3, 0, 0, 1, 0, none);
        add_row(1, 32'hffff_fffe, 1, 1, 1, 0, none);
        // last mark on the first operand changes nothing
        add_row(0, 1, 1, 1, 1, 0, none);
        add_row(0, 2, 1, 0, 1, 0, none);
        add_row(0, 3, 0, 1, 1, 0, none);
        add_row(1, 4, 0, 0, 1, 0, none);
        add_row(1, 5, 1, 1, 1, 0, none);
        add_row(0, 10, 0, 0, 3, 0, none);
        add_row(1, 20, 1, 0, 1, 0, none);
        add_row(0, 30, 1, 0, 1, 0, none);
        add_row(1, 40, 1, 0, 4, 0, none);
        // interleaved operands
        add_row(1, 100, 0, 1, 1, 0, none);
        add_row(0, 200, 0, 0, 1, 0, none);
        add_row(1, 300, 0, 0, 1, 0, none);
        add_row(0, 400, 1, 0, 1, 0, none);
        add_row(1, 500, 1, 1, 1, 0, none);
        // both operands overflow, the second drops its last coefficient, largest product
        add_row(0, 32'h7fff_fff0, 0, 0, 33, 0, none);
        add_row(1, 32'h8000_0001, 1, 1, 33, 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < script.size(); i++)
        begin
            r = script[i];
            for (int j = 0; j < r.reps; j++)
                send_coefficient(r.op, r.value + j, r.is_last && (j == r.reps - 1), r.mul,
                                 r.typed, r.want);
        end

        random_start = coeffs_sent;
        op_idx = 0;
        while (coeffs_sent - random_start < RANDOM_ITEMS)
        begin
            sender_calm = (op_idx % 4 == 1) || (op_idx == 0);
            broken = ($urandom_range(0, 4) == 0);
            if (op_idx == 0)
            begin
                // hold off the result side while the sender keeps going
                stall_request = 1'b1;
                n1 = 6;
                n2 = 6;
                mul = 1'b1;
                broken = 1'b0;
            end
            else
            begin
                n1 = pick_len(0);
                n2 = pick_len(1);
                mul = $urandom_range(0, 1);
            end
            if (!broken)
            begin
                for (int j = 0; j < n1; j++)
                    send_coefficient(0, pick_coeff(), j == n1 - 1, $urandom_range(0, 1),
                                     0, none);
                for (int j = 0; j < n2 - 1; j++)
                    send_coefficient(1, pick_coeff(), 0, $urandom_range(0, 1), 0, none);
            end
            else
            begin
                first_left = n1;
                second_left = n2 - 1;
                while (first_left + second_left > 0)
                begin
                    if (second_left == 0 || (first_left > 0 && $urandom_range(0, 1) == 0))
                    begin
                        send_coefficient(0, pick_coeff(), $urandom_range(0, 1),
                                         $urandom_range(0, 1), 0, none);
                        first_left--;
                    end
                    else
                    begin
                        send_coefficient(1, pick_coeff(), $urandom_range(0, 7) == 0,
                                         $urandom_range(0, 1), 0, none);
                        second_left--;
                    end
                end
            end
            send_coefficient(1, pick_coeff(), 1, mul, 0, none);
            op_idx++;
        end

        push <= 1'b0;
        while (expected_terms.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d coefficient transactions in %0d operations, checked %0d result terms",
                 coeffs_sent, ops_done, terms_checked);
        $display("input held back %0d cycles by a full queue, result side held off %0d cycles",
                 backpressure_cycles, LONG_HOLD);
        if (failures == 0 && expected_terms.size() == 0)
            $display("polynomial_multiply_add_tb: PASS");
        else
            $display("polynomial_multiply_add_tb: FAIL");
        $finish;
    end

endmodule
